// File: sv/scfr_pkg.sv
// Shared types and constants for the sum-checked frame receiver.
// Used by the front parser, the job queue, the back emitter and the top level.
package scfr_pkg;

    // Framing bytes
    localparam logic [7:0] SYNC_A     = 8'hEE;
    localparam logic [7:0] SYNC_B     = 8'hEF;
    localparam logic [7:0] TAIL_A     = 8'hFE;
    localparam logic [7:0] TAIL_B     = 8'hFF;
    localparam logic [7:0] RETRY_FUNC = 8'hE0 | 8'h03;
    localparam logic [7:0] RETRY_SUM  = 8'(SYNC_A + SYNC_B + RETRY_FUNC);
    localparam logic [7:0] WORD_FUNC_RESET = 8'hA1;
    localparam logic [7:0] HEADER_LEN = 8'd4;
    localparam logic [7:0] MIN_LEN    = 8'd5;

    // Retry frame is six bytes long
    localparam int unsigned RETRY_LEN = 6;
    localparam int unsigned RETRY_CW  = 3;

    // Payload storage: two banks, even and odd bytes in separate RAMs
    localparam int unsigned WIDX_W    = 6;
    localparam int unsigned RAM_DEPTH = 2 * (2 ** WIDX_W);
    localparam int unsigned RAM_AW    = WIDX_W + 1;

    // Result kind codes
    localparam logic [1:0] KIND_WORD   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_RETRY  = 2'd2;

    // Job codes passed from front to back
    localparam logic [1:0] JOB_WORDS  = 2'd0;
    localparam logic [1:0] JOB_ACCEPT = 2'd1;
    localparam logic [1:0] JOB_RETRY  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        func;
        logic [WIDX_W-1:0] nwords;
        logic              bank;
    } t_job;

    typedef struct packed {
        logic              we_even;
        logic              we_odd;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

    typedef struct packed {
        logic              re;
        logic [RAM_AW-1:0] addr;
    } t_ram_rd;

    // Byte of the retry request frame
    function automatic logic [7:0] retry_byte(input logic [RETRY_CW-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = SYNC_A;
            3'd1: b = SYNC_B;
            3'd2: b = RETRY_FUNC;
            3'd3: b = RETRY_SUM;
            3'd4: b = TAIL_A;
            3'd5: b = TAIL_B;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: sv/sum_checked_frame_receiver.sv
// Receiver for EE EF framed packets with 8-bit additive checksum.
// Output: each word takes one paired read of the even/odd payload RAMs and its own
//   emit state; retry bytes leave one per cycle while the output is not stalled.
// Throughput: one byte per cycle; input stalls while two finished frames are pending.
// Reset: synchronous, active low; clears parser, queue and emitter, not payload RAM.
module sum_checked_frame_receiver #(
    parameter int unsigned LENGTH_LIMIT = 100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_rx_valid,
    output logic               o_rx_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_word_value,
    output logic [5:0]         o_word_index,
    output logic [7:0]         o_function_code,
    output logic [7:0]         o_tx_byte,
    output logic               o_last
);
    import scfr_pkg::*;

    logic [7:0] r_word_func;
    logic       rx_accept;
    logic       push;
    t_job       push_job;
    t_ram_wr    ram_wr;
    t_ram_rd    ram_rd;
    logic       q_valid;
    t_job       q_job;
    logic [1:0] q_count;
    logic       pop;
    logic       back_busy;
    logic [7:0] even_data;
    logic [7:0] odd_data;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_func <= WORD_FUNC_RESET;
        end else if (i_cfg_we) begin
            r_word_func <= i_cfg_data;
        end
    end

    // Hold input while two frames are outstanding: both payload banks in use
    assign o_rx_stall = ({1'b0, q_count} + {2'b00, back_busy}) >= 3'd2;
    assign rx_accept  = i_rx_valid && !o_rx_stall;

    scfr_front #(
        .LENGTH_LIMIT(LENGTH_LIMIT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (rx_accept),
        .i_byte      (i_rx_byte),
        .i_word_func (r_word_func),
        .o_push      (push),
        .o_job       (push_job),
        .o_wr        (ram_wr)
    );

    scfr_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_ram_even (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we_even),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_re    (ram_rd.re),
        .i_raddr (ram_rd.addr),
        .o_rdata (even_data)
    );

    scfr_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_ram_odd (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we_odd),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_re    (ram_rd.re),
        .i_raddr (ram_rd.addr),
        .o_rdata (odd_data)
    );

    scfr_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_count (q_count)
    );

    scfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (q_valid),
        .i_job           (q_job),
        .o_pop           (pop),
        .o_busy          (back_busy),
        .o_rd            (ram_rd),
        .i_even_data     (even_data),
        .i_odd_data      (odd_data),
        .o_res_valid     (o_res_valid),
        .i_res_stall     (i_res_stall),
        .o_kind          (o_kind),
        .o_word_value    (o_word_value),
        .o_word_index    (o_word_index),
        .o_function_code (o_function_code),
        .o_tx_byte       (o_tx_byte),
        .o_last          (o_last)
    );

endmodule

// File: sv/scfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scfr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/scfr_front.sv
// Front parser: walks the frame byte by byte, stores payload, checks the sum
// and pushes one job per completed frame. Depends on scfr_pkg.
module scfr_front #(
    parameter int unsigned LENGTH_LIMIT = 100
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_word_func,
    output logic              o_push,
    output scfr_pkg::t_job    o_job,
    output scfr_pkg::t_ram_wr o_wr
);
    import scfr_pkg::*;

    localparam logic [7:0] LEN_LIMIT = 8'(LENGTH_LIMIT);

    localparam logic [2:0] PH_SYNC_A = 3'd0;
    localparam logic [2:0] PH_SYNC_B = 3'd1;
    localparam logic [2:0] PH_FUNC   = 3'd2;
    localparam logic [2:0] PH_LEN    = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_SUM    = 3'd5;
    localparam logic [2:0] PH_TAIL_A = 3'd6;
    localparam logic [2:0] PH_TAIL_B = 3'd7;

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_func, n_func;
    logic [6:0] r_pay, n_pay;       // payload byte count of this frame
    logic [6:0] r_rem, n_rem;
    logic [6:0] r_wpos, n_wpos;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_rsum, n_rsum;
    logic       r_bank, n_bank;
    logic [WIDX_W-1:0] nwords;

    assign nwords = r_pay[6:1];

    // Frame parser
    always_comb begin
        n_phase = r_phase;
        n_func  = r_func;
        n_pay   = r_pay;
        n_rem   = r_rem;
        n_wpos  = r_wpos;
        n_sum   = r_sum;
        n_rsum  = r_rsum;
        n_bank  = r_bank;
        o_push  = 1'b0;
        o_job   = '0;
        o_job.func = r_func;
        o_job.bank = r_bank;
        if (r_sum != r_rsum) begin
            o_job.kind = JOB_RETRY;
        end else if (r_func == i_word_func && nwords != '0) begin
            o_job.kind   = JOB_WORDS;
            o_job.nwords = nwords;
        end else begin
            o_job.kind = JOB_ACCEPT;
        end
        if (i_accept) begin
            case (r_phase)
                PH_SYNC_A: begin
                    if (i_byte == SYNC_A) begin
                        n_phase = PH_SYNC_B;
                        n_sum   = i_byte;
                    end
                end
                PH_SYNC_B: begin
                    n_phase = (i_byte == SYNC_B) ? PH_FUNC : PH_SYNC_A;
                    n_sum   = r_sum + i_byte;
                end
                PH_FUNC: begin
                    n_phase = (i_byte != 8'hFF) ? PH_LEN : PH_SYNC_A;
                    n_func  = i_byte;
                    n_sum   = r_sum + i_byte;
                end
                PH_LEN: begin
                    if (i_byte >= MIN_LEN && i_byte < LEN_LIMIT) begin
                        n_phase = PH_DATA;
                        n_pay   = 7'(i_byte - HEADER_LEN);
                        n_rem   = 7'(i_byte - HEADER_LEN);
                        n_wpos  = '0;
                        n_sum   = r_sum + i_byte;
                    end else begin
                        n_phase = PH_SYNC_A;
                    end
                end
                PH_DATA: begin
                    n_wpos = r_wpos + 7'd1;
                    n_sum  = r_sum + i_byte;
                    n_rem  = r_rem - 7'd1;
                    if (r_rem == 7'd1) begin
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    n_rsum  = i_byte;
                    n_phase = PH_TAIL_A;
                end
                PH_TAIL_A: begin
                    n_phase = (i_byte == TAIL_A) ? PH_TAIL_B : PH_SYNC_A;
                end
                PH_TAIL_B: begin
                    n_phase = PH_SYNC_A;
                    if (i_byte == TAIL_B) begin
                        o_push = 1'b1;
                        n_bank = ~r_bank;
                    end
                end
                default: begin
                    n_phase = PH_SYNC_A;
                end
            endcase
        end
    end

    // Payload write: even bytes and odd bytes go to separate RAMs
    always_comb begin
        o_wr.we_even = i_accept && (r_phase == PH_DATA) && !r_wpos[0];
        o_wr.we_odd  = i_accept && (r_phase == PH_DATA) && r_wpos[0];
        o_wr.addr    = {r_bank, r_wpos[6:1]};
        o_wr.data    = i_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC_A;
            r_func  <= '0;
            r_pay   <= '0;
            r_rem   <= '0;
            r_wpos  <= '0;
            r_sum   <= '0;
            r_rsum  <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_func  <= n_func;
            r_pay   <= n_pay;
            r_rem   <= n_rem;
            r_wpos  <= n_wpos;
            r_sum   <= n_sum;
            r_rsum  <= n_rsum;
            r_bank  <= n_bank;
        end
    end

endmodule

// File: sv/scfr_jobq.sv
// Two-entry job queue between the front parser and the back emitter.
// Depends on scfr_pkg.
module scfr_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scfr_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output scfr_pkg::t_job o_job,
    output logic [1:0]     o_count
);
    import scfr_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

// File: sv/scfr_back.sv
// Back emitter: takes one job at a time and produces its result words into
// a registered output stage. Depends on scfr_pkg.
module scfr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  scfr_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_busy,
    output scfr_pkg::t_ram_rd   o_rd,
    input  logic [7:0]          i_even_data,
    input  logic [7:0]          i_odd_data,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output logic [1:0]          o_kind,
    output logic signed [15:0]  o_word_value,
    output logic [5:0]          o_word_index,
    output logic [7:0]          o_function_code,
    output logic [7:0]          o_tx_byte,
    output logic                o_last
);
    import scfr_pkg::*;

    localparam logic [2:0] BK_IDLE  = 3'd0;
    localparam logic [2:0] BK_RD    = 3'd1;
    localparam logic [2:0] BK_EMIT  = 3'd2;
    localparam logic [2:0] BK_RETRY = 3'd3;
    localparam logic [2:0] BK_ACC   = 3'd4;

    localparam logic [RETRY_CW-1:0] RETRY_LAST = RETRY_CW'(RETRY_LEN - 1);

    logic [2:0]          r_state, n_state;
    t_job                r_job, n_job;
    logic [WIDX_W-1:0]   r_widx, n_widx;
    logic [RETRY_CW-1:0] r_rcnt, n_rcnt;

    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_kind, n_kind;
    logic signed [15:0] r_value, n_value;
    logic [5:0]         r_index, n_index;
    logic [7:0]         r_func, n_func;
    logic [7:0]         r_tx, n_tx;
    logic               r_last, n_last;

    logic out_free;
    logic word_last;

    assign out_free  = !r_out_valid || !i_res_stall;
    assign word_last = (r_widx == r_job.nwords - WIDX_W'(1));

    // Job sequencer and output stage load
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_widx      = r_widx;
        n_rcnt      = r_rcnt;
        n_out_valid = r_out_valid && i_res_stall;
        n_kind      = r_kind;
        n_value     = r_value;
        n_index     = r_index;
        n_func      = r_func;
        n_tx        = r_tx;
        n_last      = r_last;
        o_pop       = 1'b0;
        o_rd.re     = 1'b0;
        o_rd.addr   = {r_job.bank, r_widx};
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_pop  = 1'b1;
                    n_job  = i_job;
                    n_widx = '0;
                    n_rcnt = '0;
                    case (i_job.kind)
                        JOB_WORDS: n_state = BK_RD;
                        JOB_RETRY: n_state = BK_RETRY;
                        default:   n_state = BK_ACC;
                    endcase
                end
            end
            BK_RD: begin
                o_rd.re = 1'b1;
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_WORD;
                    n_value     = {i_even_data, i_odd_data};
                    n_index     = r_widx;
                    n_func      = r_job.func;
                    n_tx        = '0;
                    n_last      = word_last;
                    if (word_last) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_widx  = r_widx + WIDX_W'(1);
                        n_state = BK_RD;
                    end
                end
            end
            BK_RETRY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_RETRY;
                    n_value     = '0;
                    n_index     = '0;
                    n_func      = r_job.func;
                    n_tx        = retry_byte(r_rcnt);
                    n_last      = (r_rcnt == RETRY_LAST);
                    n_rcnt      = r_rcnt + RETRY_CW'(1);
                    if (r_rcnt == RETRY_LAST) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            BK_ACC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_ACCEPT;
                    n_value     = '0;
                    n_index     = '0;
                    n_func      = r_job.func;
                    n_tx        = '0;
                    n_last      = 1'b1;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Job context and output payload
    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_widx  <= n_widx;
        r_rcnt  <= n_rcnt;
        r_kind  <= n_kind;
        r_value <= n_value;
        r_index <= n_index;
        r_func  <= n_func;
        r_tx    <= n_tx;
        r_last  <= n_last;
    end

    assign o_busy          = (r_state != BK_IDLE);
    assign o_res_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_word_value    = r_value;
    assign o_word_index    = r_index;
    assign o_function_code = r_func;
    assign o_tx_byte       = r_tx;
    assign o_last          = r_last;

endmodule
